>>> design/mh2_pkg.sv
// ----------------------------------------------------------------------------
// mh2_pkg
// Shared constants and types for the byte-stream MurmurHash2 engine.
// ----------------------------------------------------------------------------
package mh2_pkg;

    // Hash constants
    localparam logic [31:0] MIX_MULT     = 32'h5bd1e995;
    localparam int          WORD_SHIFT   = 24;
    localparam int          AVAL_SHIFT_A = 13;
    localparam int          AVAL_SHIFT_B = 15;

    // Default depth of the command queue between front and back
    localparam int          QUEUE_DEPTH  = 4;

    // One command from the front end to the mixing back end
    typedef struct packed {
        logic        seed_en;   // load accumulator with seed
        logic [31:0] seed;
        logic        word_en;   // mix one full word
        logic [31:0] word;
        logic        final_en;  // finalize and emit hash
        logic        tail_en;   // fold tail bytes before avalanche
        logic [23:0] tail;
    } t_cmd;

endpackage

>>> design/mh2_front.sv
// ----------------------------------------------------------------------------
// mh2_front
// Accepts byte transactions, packs bytes little-endian into words and
// issues seed / word / finalize commands to the queue.
// ----------------------------------------------------------------------------
module mh2_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_data_byte,
    input  logic              i_byte_valid,
    input  logic              i_first,
    input  logic              i_last,
    input  logic [31:0]       i_total_length,
    input  logic              i_q_full,
    output logic              o_push,
    output mh2_pkg::t_cmd     o_cmd
);

    logic [23:0] r_pend, n_pend;
    logic [1:0]  r_phase, n_phase;
    logic [23:0] pend_s;
    logic [1:0]  phase_s;
    logic        accept;
    logic        word_en;
    logic [31:0] word;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    // Byte packing and command build
    always_comb begin
        phase_s = i_first ? 2'd0 : r_phase;
        pend_s  = i_first ? 24'd0 : r_pend;
        word_en = 1'b0;
        word    = {i_data_byte, pend_s};
        n_pend  = pend_s;
        n_phase = phase_s;
        if (i_byte_valid) begin
            unique case (phase_s)
                2'd0: n_pend[7:0]   = i_data_byte;
                2'd1: n_pend[15:8]  = i_data_byte;
                2'd2: n_pend[23:16] = i_data_byte;
                default: begin
                    word_en = 1'b1;
                    n_pend  = 24'd0;
                end
            endcase
            n_phase = phase_s + 2'd1;
        end

        o_cmd.seed_en  = i_first;
        o_cmd.seed     = i_total_length;
        o_cmd.word_en  = word_en;
        o_cmd.word     = word;
        o_cmd.final_en = i_last;
        o_cmd.tail_en  = (n_phase != 2'd0);
        o_cmd.tail     = n_pend;

        if (i_last) begin
            n_pend  = 24'd0;
            n_phase = 2'd0;
        end
    end

    assign o_push = accept && (i_first || word_en || i_last);

    // Packing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 24'd0;
            r_phase <= 2'd0;
        end else if (accept) begin
            r_pend  <= n_pend;
            r_phase <= n_phase;
        end
    end

endmodule

>>> design/mh2_queue.sv
// ----------------------------------------------------------------------------
// mh2_queue
// Small command FIFO that decouples the byte front end from the mixer.
// ----------------------------------------------------------------------------
module mh2_queue #(
    parameter int DEPTH = mh2_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mh2_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output mh2_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    mh2_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_IDX) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_IDX) ? '0 : r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

>>> design/mh2_back.sv
// ----------------------------------------------------------------------------
// mh2_back
// Mixing sequencer: applies queued commands to the accumulator with one
// shared multiply-by-constant and holds the finished hash in an output
// register.
// ----------------------------------------------------------------------------
module mh2_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mh2_pkg::t_cmd i_cmd,
    input  logic          i_q_empty,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [31:0]   o_hash_value
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WK1  = 3'd1;
    localparam logic [2:0] S_WK2  = 3'd2;
    localparam logic [2:0] S_WH   = 3'd3;
    localparam logic [2:0] S_FT   = 3'd4;
    localparam logic [2:0] S_FA   = 3'd5;
    localparam logic [2:0] S_FO   = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [31:0]   r_h, n_h;
    logic [31:0]   r_k, n_k;
    mh2_pkg::t_cmd r_ent, n_ent;
    logic          r_out_valid, n_out_valid;
    logic [31:0]   r_hash, n_hash;
    logic [31:0]   mul_in;
    logic [31:0]   mul_out;
    logic          out_free;

    // Shared constant multiplier, low 32 bits kept
    assign mul_out  = mul_in * mh2_pkg::MIX_MULT;
    assign out_free = !r_out_valid || i_ready;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_h         = r_h;
        n_k         = r_k;
        n_ent       = r_ent;
        n_hash      = r_hash;
        n_out_valid = r_out_valid && !i_ready;
        mul_in      = r_k;
        o_pop       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    n_ent = i_cmd;
                    n_k   = i_cmd.word;
                    if (i_cmd.seed_en) begin
                        n_h = i_cmd.seed;
                    end
                    if (i_cmd.word_en) begin
                        n_state = S_WK1;
                    end else if (i_cmd.final_en) begin
                        n_state = S_FT;
                    end
                end
            end
            S_WK1: begin
                mul_in  = r_k;
                n_k     = mul_out;
                n_state = S_WK2;
            end
            S_WK2: begin
                mul_in  = r_k ^ (r_k >> mh2_pkg::WORD_SHIFT);
                n_k     = mul_out;
                n_state = S_WH;
            end
            S_WH: begin
                mul_in  = r_h;
                n_h     = mul_out ^ r_k;
                n_state = r_ent.final_en ? S_FT : S_IDLE;
            end
            S_FT: begin
                // fold tail bytes in when any are pending
                mul_in = r_h ^ {8'd0, r_ent.tail};
                if (r_ent.tail_en) begin
                    n_h = mul_out;
                end
                n_state = S_FA;
            end
            S_FA: begin
                mul_in  = r_h ^ (r_h >> mh2_pkg::AVAL_SHIFT_A);
                n_h     = mul_out;
                n_state = S_FO;
            end
            S_FO: begin
                if (out_free) begin
                    n_hash      = r_h ^ (r_h >> mh2_pkg::AVAL_SHIFT_B);
                    n_out_valid = 1'b1;
                    n_h         = 32'd0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_h         <= 32'd0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_h         <= n_h;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_ent  <= n_ent;
        r_hash <= n_hash;
    end

    assign o_valid      = r_out_valid;
    assign o_hash_value = r_hash;

endmodule

>>> design/murmurhash2_byte_stream.sv
// ----------------------------------------------------------------------------
// murmurhash2_byte_stream
// Throughput: one byte transaction per cycle while the command queue has room;
// the mixer makes three multiplier passes per 32-bit word and runs states S_FT, S_FA and
// S_FO per finalize, so long strings are sustained at one byte per cycle.
// A last byte runs S_FT, S_FA, S_FO before o_valid (first S_WK1, S_WK2, S_WH if it ends a word).
// Reset: synchronous active-low; accumulator, packing state, queue cleared.
// ----------------------------------------------------------------------------
module murmurhash2_byte_stream #(
    parameter int QUEUE_DEPTH = mh2_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_first,
    input  logic        i_last,
    input  logic [31:0] i_total_length,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_hash_value
);

    mh2_pkg::t_cmd push_cmd;
    mh2_pkg::t_cmd head_cmd;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;

    // Byte front end
    mh2_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_byte_valid   (i_byte_valid),
        .i_first        (i_first),
        .i_last         (i_last),
        .i_total_length (i_total_length),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    // Command queue
    mh2_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Mixer back end
    mh2_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (head_cmd),
        .i_q_empty    (q_empty),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hash_value (o_hash_value)
    );

endmodule

>>> design/mh2_checker.sv
// ----------------------------------------------------------------------------
// mh2_checker
// Port-level checks for the MurmurHash2 engine, bound to the top level.
// ----------------------------------------------------------------------------
module mh2_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        i_last,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_hash_value
);

    logic [7:0] r_open;
    logic       last_in;
    logic       hash_out;

    assign last_in  = i_valid && o_ready && i_last;
    assign hash_out = o_valid && i_ready;

    // Strings closed on the input but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 8'd0;
        end else if (last_in && !hash_out) begin
            r_open <= r_open + 8'd1;
        end else if (hash_out && !last_in) begin
            r_open <= r_open - 8'd1;
        end
    end

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_hash_value))
        else $error("hash result changed while stalled");

    // No result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Every result answers a closed string
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_open != 8'd0)
        else $error("hash result without a finished string");

endmodule

bind murmurhash2_byte_stream mh2_checker u_mh2_checker (.*);
